FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the echo block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// cond must never hold at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/fde_pkg.sv
// Types, register codes and helpers for the feedback delay echo.
package fde_pkg;

   typedef logic signed [15:0] sample_type;

   // sequencer phase of the item that owns the multiplier
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FB,
      PH_DRY,
      PH_WET
   } phase_type;

   // register indexes of the write port
   localparam logic [1:0] CSR_DELAY    = 2'd0;
   localparam logic [1:0] CSR_MIX_WET  = 2'd1;
   localparam logic [1:0] CSR_FEEDBACK = 2'd2;
   localparam logic [1:0] CSR_CHANNELS = 2'd3;

   // register reset values
   localparam logic [15:0] DELAY_RST    = 16'd13230;
   localparam logic [15:0] MIX_WET_RST  = 16'd16384;
   localparam logic [14:0] FEEDBACK_RST = 15'd16384;
   localparam logic [1:0]  CHANNELS_RST = 2'd2;

   localparam logic [15:0] UNITY_Q15 = 16'd32768;

   // clamp a 20-bit signed value to 16 bits
   function automatic sample_type sat16(input logic signed [19:0] v);
      sample_type r;
      if (v > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/fde_ram.sv
// Generic simple dual-port RAM with registered read.
module fde_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/feedback_delay_echo.sv
// Top level of the multichannel feedback delay echo.
//
// Requests (req_channel, req_sample_in) enter on a valid/ready channel; each
// yields one mixed sample on the rsp_ channel, in request order.
// Each item runs phases PH_FB, PH_DRY, PH_WET, then the fin_ff holding stage.
// The next request is taken no sooner than the prior item's PH_WET, as one
// shared 17x17 datapath multiplier forms feedback, dry and wet products in turn.
// The echo RAM (BUFFER_LEN words per channel buffer) is read in the accept
// cycle and written back in PH_DRY, before the next read can issue.
// Reset: a clearing pass writes zero to all min(CHANNELS,2)*BUFFER_LEN RAM
// words, one per cycle; req_ready stays low until the pass is done.
// The delay register is reduced modulo BUFFER_LEN by a reciprocal multiply
// and a subtraction after reset and after every delay write; req_ready is
// low while that runs. Other register writes take effect at once.
// Stall: a finished result waits in a holding stage while rsp_valid is held;
// the next request still goes through its read and its first products,
// and stops before its last product until the response register frees up.
`include "assert_macros.svh"

module feedback_delay_echo #(
   parameter int BUFFER_LEN = 65536,
   parameter int CHANNELS   = 2
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_channel,
   input  fde_pkg::sample_type req_sample_in,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fde_pkg::sample_type rsp_sample_out,
   // register write port
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);

   import fde_pkg::*;

   // buffers actually addressable: the channel field is one bit wide
   localparam int NBUF  = (CHANNELS > 1) ? 2 : 1;
   localparam int DEPTH = NBUF * BUFFER_LEN;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(BUFFER_LEN);

   localparam logic [PW:0]    LEN_W    = (PW + 1)'(BUFFER_LEN);
   localparam logic [PW-1:0]  POS_LAST = PW'(BUFFER_LEN - 1);
   localparam logic [AW-1:0]  BUF1_OFS = AW'(BUFFER_LEN);
   localparam logic [AW-1:0]  CLR_LAST = AW'(DEPTH - 1);
   localparam logic [1:0]     CNT_LIM  = (CHANNELS > 1) ? 2'd2 : 2'd1;

   // quotient of a 16-bit value by BUFFER_LEN is (v * RCP_M) >> RCP_S
   localparam int             RCP_S    = 16 + $clog2(BUFFER_LEN);
   localparam logic [16:0]    RCP_M    = 17'(((64'd1 << RCP_S) + 64'(BUFFER_LEN) - 64'd1)
                                             / 64'(BUFFER_LEN));
   localparam logic [15:0]    LEN_LO   = 16'(BUFFER_LEN);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [15:0] delay_ff;     // raw delay, reduced in place mod BUFFER_LEN
   logic [15:0] mix_wet_ff;
   logic [14:0] feedback_ff;
   logic [1:0]  chan_cnt_ff;

   logic [32:0] rcp_prod_ff;  // delay times the reciprocal of BUFFER_LEN
   logic        red_k_ff;
   logic        red_busy_ff;
   logic [32:0] rcp_prod;
   logic [15:0] rcp_quot;
   logic [15:0] rcp_back;

   logic delay_wr;
   assign delay_wr = csr_write_en && (csr_index == CSR_DELAY);

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_wet_ff  <= MIX_WET_RST;
         feedback_ff <= FEEDBACK_RST;
         chan_cnt_ff <= CHANNELS_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DELAY:    ;
            CSR_MIX_WET:  mix_wet_ff  <= csr_data;
            CSR_FEEDBACK: feedback_ff <= csr_data[14:0];
            CSR_CHANNELS: chan_cnt_ff <= csr_data[1:0];
         endcase
      end
   end

   assign rcp_prod = {17'd0, delay_ff} * {16'd0, RCP_M};
   assign rcp_quot = 16'(rcp_prod_ff >> RCP_S);
   assign rcp_back = rcp_quot * LEN_LO;

   always_ff @(posedge clock) begin
      rcp_prod_ff <= rcp_prod;
   end

   // modulo in two steps: reciprocal product, then subtract quotient * length
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= DELAY_RST;
         red_k_ff    <= 1'b0;
         red_busy_ff <= 1'b1;
      end else if (delay_wr) begin
         delay_ff    <= csr_data;
         red_k_ff    <= 1'b0;
         red_busy_ff <= 1'b1;
      end else if (red_busy_ff) begin
         red_k_ff <= 1'b1;
         if (red_k_ff) begin
            delay_ff    <= delay_ff - rcp_back;
            red_busy_ff <= 1'b0;
         end
      end
   end

   // wet gain saturates at unity, dry is its complement
   logic [15:0] wet_gain;
   logic [15:0] dry_gain;
   assign wet_gain = (mix_wet_ff > UNITY_Q15) ? UNITY_Q15 : mix_wet_ff;
   assign dry_gain = UNITY_Q15 - wet_gain;

   // ---------------------------------------------------------------
   // clearing pass after reset
   // ---------------------------------------------------------------
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == CLR_LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   phase_type phase_ff, phase_in;
   logic      fin_ff;         // dry and wet terms wait for the rsp register
   logic      rsp_valid_ff;
   logic      fin_go;
   logic      wet_go;
   logic      req_acc;

   assign fin_go = fin_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      phase_in  = phase_ff;
      wet_go    = 1'b0;
      req_ready = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            req_ready = !clr_busy_ff && !red_busy_ff;
         end
         PH_FB: begin
            phase_in = PH_DRY;
         end
         PH_DRY: begin
            phase_in = PH_WET;
         end
         PH_WET: begin
            // last product only goes once the holding stage is free
            wet_go    = !fin_ff || fin_go;
            req_ready = wet_go && !clr_busy_ff && !red_busy_ff;
            if (wet_go) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      if (req_valid && req_ready) begin
         phase_in = PH_FB;
      end
   end

   assign req_acc = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // ---------------------------------------------------------------
   // write position and read address
   // ---------------------------------------------------------------
   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic [PW-1:0] dly;
   logic [PW:0]   rd_diff;
   logic [PW:0]   rd_wrap;
   logic [PW-1:0] rd_pos;
   logic          buf_sel;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr_cur;
   logic [1:0]    cnt_clamp;
   logic          pos_adv;

   assign dly     = PW'(delay_ff);
   assign rd_diff = {1'b0, pos_ff} - {1'b0, dly};
   assign rd_wrap = {1'b0, pos_ff} + LEN_W - {1'b0, dly};
   assign rd_pos  = rd_diff[PW] ? rd_wrap[PW-1:0] : rd_diff[PW-1:0];
   assign buf_sel = (NBUF > 1) ? req_channel : 1'b0;

   assign rd_addr     = buf_sel ? (BUF1_OFS + AW'(rd_pos)) : AW'(rd_pos);
   assign wr_addr_cur = buf_sel ? (BUF1_OFS + AW'(pos_ff)) : AW'(pos_ff);

   // count 0 acts as 1, counts above the buffers present clamp down
   always_comb begin
      cnt_clamp = chan_cnt_ff;
      if (chan_cnt_ff == 2'd0) begin
         cnt_clamp = 2'd1;
      end else if (chan_cnt_ff > CNT_LIM) begin
         cnt_clamp = CNT_LIM;
      end
   end

   assign pos_adv = (cnt_clamp == 2'd1) || req_channel;
   assign pos_in  = (pos_ff == POS_LAST) ? '0 : pos_ff + PW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (req_acc && pos_adv) begin
         pos_ff <= pos_in;
      end
   end

   // ---------------------------------------------------------------
   // echo RAM
   // ---------------------------------------------------------------
   sample_type    x_ff;
   sample_type    d_ff;
   logic [AW-1:0] wa_ff;
   logic signed [33:0] prod_ff;
   logic [15:0]   ram_rdata;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [15:0]   ram_wdata;
   sample_type    fb_store;

   assign fb_store  = sat16({prod_ff[33], prod_ff[33:15]});
   assign ram_we    = clr_busy_ff || (phase_ff == PH_DRY);
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : wa_ff;
   assign ram_wdata = clr_busy_ff ? 16'd0 : fb_store;

   fde_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_echo_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------
   // shared multiplier
   // ---------------------------------------------------------------
   logic signed [16:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [33:0] mul_p;

   always_comb begin
      mul_a = {d_ff[15], d_ff};
      mul_b = $signed({1'b0, wet_gain});
      case (phase_ff)
         PH_FB: begin
            // feedback term: gain * (input + delayed)
            mul_a = $signed({x_ff[15], x_ff}) + $signed({ram_rdata[15], ram_rdata});
            mul_b = $signed({2'b00, feedback_ff});
         end
         PH_DRY: begin
            mul_a = {x_ff[15], x_ff};
            mul_b = $signed({1'b0, dry_gain});
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // ---------------------------------------------------------------
   // datapath registers
   // ---------------------------------------------------------------
   logic signed [18:0] fin_dry_ff;
   logic signed [18:0] fin_wet_ff;
   sample_type         rsp_sample_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         x_ff  <= req_sample_in;
         wa_ff <= wr_addr_cur;
      end
      if (phase_ff == PH_FB) begin
         d_ff <= ram_rdata;
      end
      if ((phase_ff == PH_FB) || (phase_ff == PH_DRY)) begin
         prod_ff <= mul_p;
      end
      if (wet_go) begin
         fin_dry_ff <= prod_ff[33:15];
         fin_wet_ff <= mul_p[33:15];
      end
      if (fin_go) begin
         rsp_sample_ff <= sat16({fin_dry_ff[18], fin_dry_ff} + {fin_wet_ff[18], fin_wet_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wet_go) begin
            fin_ff <= 1'b1;
         end else if (fin_go) begin
            fin_ff <= 1'b0;
         end
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   `ASSERT_NEVER(a_no_req_in_clear, clock, reset, (clr_busy_ff || red_busy_ff) && req_ready, "request taken during clear or delay reduction")
   `ASSERT_NEVER(a_no_item_in_clear, clock, reset, clr_busy_ff && (phase_ff != PH_IDLE), "item in flight during clearing pass")
   `ASSERT_NEXT(a_fin_holds, clock, reset, fin_ff && rsp_valid_ff && !rsp_ready, fin_ff && rsp_valid_ff, "finished result lost while response stalled")
   `ASSERT_NEXT(a_wet_waits, clock, reset, (phase_ff == PH_WET) && !wet_go, (phase_ff == PH_WET) && $stable(d_ff), "last product left before holding stage was free")

endmodule
